// ----- rtl/core/sha_pkg.sv -----
// Shared types and constants for the byte-serial SHA-256 hasher.
// Holds the controller states, the command and status structs and the round constants.
// Depends on nothing; sha_ctrl, sha_dp and the top level import it.
`default_nettype none

package sha_pkg;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] FILL_MAX = 6'd63;
    localparam logic [5:0] RND_MAX  = 6'd63;
    localparam logic [2:0] WORD_MAX = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_PAD80,
        ST_ZERO,
        ST_LEN,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        BSEL_IN,
        BSEL_PAD,
        BSEL_ZERO,
        BSEL_LEN
    } bsel_t;

    typedef struct packed {
        logic  shift;
        bsel_t bsel;
        logic  count_inc;
        logic  load_work;
        logic  round;
        logic  add;
        logic  emit;
        logic  start;
    } cmd_t;

    typedef struct packed {
        logic fill_last;
        logic fill_at_len;
        logic round_last;
        logic out_free;
        logic out_last;
    } sts_t;

    function automatic logic [31:0] init_hash(input logic [2:0] idx);
        logic [31:0] val;
        unique case (idx)
            3'd0:    val = 32'h6a09e667;
            3'd1:    val = 32'hbb67ae85;
            3'd2:    val = 32'h3c6ef372;
            3'd3:    val = 32'ha54ff53a;
            3'd4:    val = 32'h510e527f;
            3'd5:    val = 32'h9b05688c;
            3'd6:    val = 32'h1f83d9ab;
            default: val = 32'h5be0cd19;
        endcase
        return val;
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] val;
        unique case (idx)
            6'd0:  val = 32'h428a2f98; 6'd1:  val = 32'h71374491;
            6'd2:  val = 32'hb5c0fbcf; 6'd3:  val = 32'he9b5dba5;
            6'd4:  val = 32'h3956c25b; 6'd5:  val = 32'h59f111f1;
            6'd6:  val = 32'h923f82a4; 6'd7:  val = 32'hab1c5ed5;
            6'd8:  val = 32'hd807aa98; 6'd9:  val = 32'h12835b01;
            6'd10: val = 32'h243185be; 6'd11: val = 32'h550c7dc3;
            6'd12: val = 32'h72be5d74; 6'd13: val = 32'h80deb1fe;
            6'd14: val = 32'h9bdc06a7; 6'd15: val = 32'hc19bf174;
            6'd16: val = 32'he49b69c1; 6'd17: val = 32'hefbe4786;
            6'd18: val = 32'h0fc19dc6; 6'd19: val = 32'h240ca1cc;
            6'd20: val = 32'h2de92c6f; 6'd21: val = 32'h4a7484aa;
            6'd22: val = 32'h5cb0a9dc; 6'd23: val = 32'h76f988da;
            6'd24: val = 32'h983e5152; 6'd25: val = 32'ha831c66d;
            6'd26: val = 32'hb00327c8; 6'd27: val = 32'hbf597fc7;
            6'd28: val = 32'hc6e00bf3; 6'd29: val = 32'hd5a79147;
            6'd30: val = 32'h06ca6351; 6'd31: val = 32'h14292967;
            6'd32: val = 32'h27b70a85; 6'd33: val = 32'h2e1b2138;
            6'd34: val = 32'h4d2c6dfc; 6'd35: val = 32'h53380d13;
            6'd36: val = 32'h650a7354; 6'd37: val = 32'h766a0abb;
            6'd38: val = 32'h81c2c92e; 6'd39: val = 32'h92722c85;
            6'd40: val = 32'ha2bfe8a1; 6'd41: val = 32'ha81a664b;
            6'd42: val = 32'hc24b8b70; 6'd43: val = 32'hc76c51a3;
            6'd44: val = 32'hd192e819; 6'd45: val = 32'hd6990624;
            6'd46: val = 32'hf40e3585; 6'd47: val = 32'h106aa070;
            6'd48: val = 32'h19a4c116; 6'd49: val = 32'h1e376c08;
            6'd50: val = 32'h2748774c; 6'd51: val = 32'h34b0bcb5;
            6'd52: val = 32'h391c0cb3; 6'd53: val = 32'h4ed8aa4a;
            6'd54: val = 32'h5b9cca4f; 6'd55: val = 32'h682e6ff3;
            6'd56: val = 32'h748f82ee; 6'd57: val = 32'h78a5636f;
            6'd58: val = 32'h84c87814; 6'd59: val = 32'h8cc70208;
            6'd60: val = 32'h90befffa; 6'd61: val = 32'ha4506ceb;
            6'd62: val = 32'hbef9a3f7;
            default: val = 32'hc67178f2;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/sha_ctrl.sv -----
// Controller state machine of the SHA-256 hasher: absorbs bytes, pads, sequences rounds
// and digest output. Drives the datapath through cmd_t and reads sts_t.
// Depends on sha_pkg.
`default_nettype none

module sha_ctrl
    import sha_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    input  wire logic byte_valid,
    input  wire logic msg_end,
    output logic      in_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (byte_valid && sts.fill_last) begin
                        state_next = ST_ROUND;
                        ret_next   = msg_end ? ST_PAD80 : ST_IDLE;
                    end else if (msg_end) begin
                        state_next = ST_PAD80;
                    end
                end
            end
            ST_ROUND: begin
                if (sts.round_last) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                state_next = ret_reg;
            end
            ST_PAD80: begin
                if (sts.fill_last) begin
                    state_next = ST_ROUND;
                    ret_next   = ST_ZERO;
                end else begin
                    state_next = ST_ZERO;
                end
            end
            ST_ZERO: begin
                if (sts.fill_at_len) begin
                    state_next = ST_LEN;
                end else if (sts.fill_last) begin
                    state_next = ST_ROUND;
                    ret_next   = ST_ZERO;
                end
            end
            ST_LEN: begin
                if (sts.fill_last) begin
                    state_next = ST_ROUND;
                    ret_next   = ST_OUT;
                end
            end
            ST_OUT: begin
                if (sts.out_free && sts.out_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd = '0;
        cmd.bsel = BSEL_IN;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && byte_valid) begin
                    cmd.shift     = 1'b1;
                    cmd.bsel      = BSEL_IN;
                    cmd.count_inc = 1'b1;
                    cmd.load_work = sts.fill_last;
                end
            end
            ST_ROUND: begin
                cmd.round = 1'b1;
            end
            ST_ADD: begin
                cmd.add = 1'b1;
            end
            ST_PAD80: begin
                cmd.shift     = 1'b1;
                cmd.bsel      = BSEL_PAD;
                cmd.load_work = sts.fill_last;
            end
            ST_ZERO: begin
                if (!sts.fill_at_len) begin
                    cmd.shift     = 1'b1;
                    cmd.bsel      = BSEL_ZERO;
                    cmd.load_work = sts.fill_last;
                end
            end
            ST_LEN: begin
                cmd.shift     = 1'b1;
                cmd.bsel      = BSEL_LEN;
                cmd.load_work = sts.fill_last;
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    cmd.emit  = 1'b1;
                    cmd.start = sts.out_last;
                end
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/sha_dp.sv -----
// Datapath of the SHA-256 hasher: block shift register, message schedule, round unit,
// hash words, byte counter and the digest output register.
// Depends on sha_pkg; driven by sha_ctrl.
`default_nettype none

module sha_dp
    import sha_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [7:0]  in_byte,
    input  wire cmd_t        cmd,
    output sts_t             sts,
    input  wire logic        out_ready,
    output logic             out_valid,
    output logic [31:0]      out_word,
    output logic [2:0]       out_index,
    output logic             out_last
);

    logic [511:0] blk_reg, blk_next;
    logic [31:0]  work_reg [8];
    logic [31:0]  hash_reg [8];
    logic [63:0]  count_reg;
    logic [5:0]   fill_reg;
    logic [5:0]   rnd_reg;
    logic [2:0]   ocnt_reg;
    logic         oval_reg;
    logic [31:0]  oword_reg;
    logic [2:0]   oidx_reg;

    logic [7:0]   byte_sel;
    logic [63:0]  len_shift;
    logic [31:0]  w0, w1, w9, w14, w_new;
    logic [31:0]  t1, t2;
    logic [31:0]  ea, eb, ec, ed, ee, ef, eg, eh;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    assign len_shift = {count_reg[60:0], 3'b000} << {fill_reg[2:0], 3'b000};

    always_comb begin
        unique case (cmd.bsel)
            BSEL_IN:   byte_sel = in_byte;
            BSEL_PAD:  byte_sel = PAD_BYTE;
            BSEL_ZERO: byte_sel = 8'h00;
            default:   byte_sel = len_shift[63:56];
        endcase
    end

    assign w0  = blk_reg[511:480];
    assign w1  = blk_reg[479:448];
    assign w9  = blk_reg[223:192];
    assign w14 = blk_reg[63:32];
    assign w_new = w0 + w9
                 + (rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3))
                 + (rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10));

    assign ea = work_reg[0];
    assign eb = work_reg[1];
    assign ec = work_reg[2];
    assign ed = work_reg[3];
    assign ee = work_reg[4];
    assign ef = work_reg[5];
    assign eg = work_reg[6];
    assign eh = work_reg[7];

    assign t1 = eh + (rotr(ee, 6) ^ rotr(ee, 11) ^ rotr(ee, 25))
              + ((ee & ef) ^ (~ee & eg)) + round_k(rnd_reg) + w0;
    assign t2 = (rotr(ea, 2) ^ rotr(ea, 13) ^ rotr(ea, 22))
              + ((ea & eb) ^ (ea & ec) ^ (eb & ec));

    always_comb begin
        blk_next = blk_reg;
        if (cmd.shift) begin
            blk_next = {blk_reg[503:0], byte_sel};
        end else if (cmd.round) begin
            blk_next = {blk_reg[479:0], w_new};
        end
    end

    always_ff @(posedge aclk) begin
        blk_reg <= blk_next;
        if (cmd.load_work) begin
            for (int i = 0; i < 8; i++) begin
                work_reg[i] <= hash_reg[i];
            end
        end else if (cmd.round) begin
            work_reg[0] <= t1 + t2;
            work_reg[1] <= ea;
            work_reg[2] <= eb;
            work_reg[3] <= ec;
            work_reg[4] <= ed + t1;
            work_reg[5] <= ee;
            work_reg[6] <= ef;
            work_reg[7] <= eg;
        end
        if (cmd.emit) begin
            oword_reg <= hash_reg[ocnt_reg];
            oidx_reg  <= ocnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) begin
                hash_reg[i] <= init_hash(3'(i));
            end
            count_reg <= '0;
            fill_reg  <= '0;
            rnd_reg   <= '0;
            ocnt_reg  <= '0;
            oval_reg  <= 1'b0;
        end else begin
            if (cmd.start) begin
                for (int i = 0; i < 8; i++) begin
                    hash_reg[i] <= init_hash(3'(i));
                end
            end else if (cmd.add) begin
                for (int i = 0; i < 8; i++) begin
                    hash_reg[i] <= hash_reg[i] + work_reg[i];
                end
            end
            if (cmd.start) begin
                count_reg <= '0;
                fill_reg  <= '0;
            end else begin
                if (cmd.count_inc) begin
                    count_reg <= count_reg + 64'd1;
                end
                if (cmd.shift) begin
                    fill_reg <= fill_reg + 6'd1;
                end
            end
            if (cmd.load_work) begin
                rnd_reg <= '0;
            end else if (cmd.round) begin
                rnd_reg <= rnd_reg + 6'd1;
            end
            if (cmd.emit) begin
                ocnt_reg <= ocnt_reg + 3'd1;
                oval_reg <= 1'b1;
            end else if (out_ready) begin
                oval_reg <= 1'b0;
            end
        end
    end

    assign sts.fill_last   = (fill_reg == FILL_MAX);
    assign sts.fill_at_len = (fill_reg == LEN_POS);
    assign sts.round_last  = (rnd_reg == RND_MAX);
    assign sts.out_free    = !oval_reg || out_ready;
    assign sts.out_last    = (ocnt_reg == WORD_MAX);

    assign out_valid = oval_reg;
    assign out_word  = oword_reg;
    assign out_index = oidx_reg;
    assign out_last  = (oidx_reg == WORD_MAX);

endmodule

`default_nettype wire

// ----- rtl/core/sha256_stream_hasher.sv -----
// Top level of the byte-serial SHA-256 hasher: joins sha_ctrl and sha_dp.
// Depends on sha_pkg, sha_ctrl and sha_dp.
//
//   Channel  Dir  tdata                 tuser           tlast
//   s_       in   [7:0] data_byte       [0] byte_valid  msg_end
//   m_       out  [31:0] digest_word    [2:0] word_index last_word
//
// A message byte is taken while the controller is idle; the 64th byte of a block starts the
// rounds and the add step of the shared round unit, and no new byte is taken until they end.
// Ending a message shifts in padding and length one byte a cycle between compressions (one
// or two compressions), then the eight digest words leave one per cycle while m_tready is high.
// s_tready is high only while the controller waits for input; a stalled m_ side holds
// the digest sequence. Reset is synchronous, active low, and restores the initial hash.
`default_nettype none

module sha256_stream_hasher
    import sha_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic [0:0]  s_tuser,   // [0] byte_valid
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] digest_word
    output logic [2:0]       m_tuser,   // [2:0] word_index
    output logic             m_tlast
);

    cmd_t cmd;
    sts_t sts;

    sha_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .byte_valid (s_tuser[0]),
        .msg_end    (s_tlast),
        .in_ready   (s_tready),
        .sts        (sts),
        .cmd        (cmd)
    );

    sha_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_byte   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_word  (m_tdata),
        .out_index (m_tuser),
        .out_last  (m_tlast)
    );

endmodule

`default_nettype wire

// ----- rtl/core/sha_checker.sv -----
// Port-level checker for sha256_stream_hasher, attached by the bind at the end.
// Depends only on the top level's ports.
`default_nettype none

module sha_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [2:0]  m_tuser,
    input wire logic        m_tlast
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("Stalled digest item changed.");

    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser == 3'd7)))
        else $error("Last marker and word index disagree.");

    a_word_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=>
            m_tvalid && (m_tuser == $past(m_tuser) + 3'd1))
        else $error("Digest words not emitted back to back in order.");

    a_no_input_mid_digest: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("Input taken while a digest is being emitted.");

endmodule

bind sha256_stream_hasher sha_checker u_sha_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
